// ----- src/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants for the power switch sequencer: register
// indexes, register widths, reset values and the state and result records.
// ----------------------------------------------------------------------------
package pss_pkg;

    // configuration channel widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register widths fixed by the register map
    localparam int THRESH_W = 8;
    localparam int PERIOD_W = 16;
    localparam int LIMIT_W  = 10;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ON_THRESHOLD    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_THRESHOLD   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNDERVOLT_LIMIT = 3'd3;

    // register reset values
    localparam logic [THRESH_W-1:0] ON_THRESHOLD_RST    = 8'd30;
    localparam logic [THRESH_W-1:0] OFF_THRESHOLD_RST   = 8'd30;
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST   = 16'd20;
    localparam logic [LIMIT_W-1:0]  UNDERVOLT_LIMIT_RST = 10'd630;

    // configuration register file
    typedef struct packed {
        logic [THRESH_W-1:0] on_threshold;
        logic [THRESH_W-1:0] off_threshold;
        logic [PERIOD_W-1:0] sample_period;
        logic [LIMIT_W-1:0]  undervolt_limit;
    } pss_cfg_t;

    // pin levels held between ticks
    typedef struct packed {
        logic boost;
        logic sw;
        logic status;
        logic discharge;
    } pss_pins_t;

    localparam pss_pins_t PINS_RST = '{boost: 1'b0, sw: 1'b0, status: 1'b1, discharge: 1'b1};

    // one result record
    typedef struct packed {
        logic powered;
        logic boost_drive;
        logic switch_drive;
        logic status_drive;
        logic discharge_drive;
        logic checked;
    } pss_result_t;

endpackage

// ----- src/pss_if.sv -----
// ----------------------------------------------------------------------------
// pss_if
// Handshake channels of the power switch sequencer: tick input, result
// output and configuration write.
// ----------------------------------------------------------------------------

// tick channel: sense level and supply sample
interface pss_tick_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic                   sense_level;
    logic [SAMPLE_BITS-1:0] supply_sample;

    modport source (output valid, output sense_level, output supply_sample, input ready);
    modport sink   (input valid, input sense_level, input supply_sample, output ready);
endinterface

// result channel: pin levels after one tick
interface pss_result_if;
    logic valid;
    logic ready;
    logic powered;
    logic boost_drive;
    logic switch_drive;
    logic status_drive;
    logic discharge_drive;
    logic checked;

    modport source (
        output valid, output powered, output boost_drive, output switch_drive,
        output status_drive, output discharge_drive, output checked, input ready
    );
    modport sink (
        input valid, input powered, input boost_drive, input switch_drive,
        input status_drive, input discharge_drive, input checked, output ready
    );
endinterface

// configuration write channel
interface pss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/power_switch_sequencer.sv -----
// ----------------------------------------------------------------------------
// power_switch_sequencer
// Pipeline: a tick request is captured in the input register, then its
// result in the result register.
// Throughput: one tick per cycle unless the result channel stalls; the
// state update from one tick to the next is one pass through the core logic.
// Reset: asynchronous, active low; system on, boost and switch released,
// status and discharge driven, counters zero, registers at their defaults.
// ----------------------------------------------------------------------------
module power_switch_sequencer
    import pss_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int RUN_BITS    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    pss_tick_if.sink      sample_in,
    pss_result_if.source  result_out,
    pss_cfg_if.sink       cfg
);

    pss_cfg_t               cfg_reg;
    logic                   s1_valid_reg;
    logic                   s1_level_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   out_valid_reg;
    pss_result_t            result_reg;
    pss_result_t            core_result;
    logic                   s1_advance;
    logic                   in_accept;

    // handshake
    assign s1_advance      = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign sample_in.ready = !s1_valid_reg || s1_advance;
    assign in_accept       = sample_in.valid && sample_in.ready;
    assign cfg.ready       = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold    <= ON_THRESHOLD_RST;
            cfg_reg.off_threshold   <= OFF_THRESHOLD_RST;
            cfg_reg.sample_period   <= SAMPLE_PERIOD_RST;
            cfg_reg.undervolt_limit <= UNDERVOLT_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ON_THRESHOLD:    cfg_reg.on_threshold    <= cfg.data[THRESH_W-1:0];
                CFG_OFF_THRESHOLD:   cfg_reg.off_threshold   <= cfg.data[THRESH_W-1:0];
                CFG_SAMPLE_PERIOD:   cfg_reg.sample_period   <= cfg.data[PERIOD_W-1:0];
                CFG_UNDERVOLT_LIMIT: cfg_reg.undervolt_limit <= cfg.data[LIMIT_W-1:0];
                default:             ;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_in.ready)
        begin
            s1_valid_reg <= sample_in.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_level_reg  <= sample_in.sense_level;
            s1_sample_reg <= sample_in.supply_sample;
        end
    end

    // sequencer core
    pss_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RUN_BITS    (RUN_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .level   (s1_level_reg),
        .sample  (s1_sample_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_out.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= core_result;
        end
    end

    // result channel
    assign result_out.valid           = out_valid_reg;
    assign result_out.powered         = result_reg.powered;
    assign result_out.boost_drive     = result_reg.boost_drive;
    assign result_out.switch_drive    = result_reg.switch_drive;
    assign result_out.status_drive    = result_reg.status_drive;
    assign result_out.discharge_drive = result_reg.discharge_drive;
    assign result_out.checked         = result_reg.checked;

`ifndef NO_ASSERTIONS
    // a tick leaving the input register always lands in the result register
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("tick lost between input and result register");

    // status follows the power state
    a_status_power: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.status_drive == result_reg.powered))
        else $error("status pin disagrees with power state");

    // boost and switch always move together
    a_boost_switch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.boost_drive == result_reg.switch_drive))
        else $error("boost and switch pins differ");

    // when on, boost and switch are released and discharge is driven
    a_on_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.powered) |->
            (!result_reg.boost_drive && result_reg.discharge_drive))
        else $error("pin levels inconsistent with on state");
`endif

endmodule

// ----- src/pss_core.sv -----
// ----------------------------------------------------------------------------
// pss_core
// Sequencer state and the per-tick update: sense qualification counters,
// check phase counter, power state and pin levels.
// ----------------------------------------------------------------------------
module pss_core
    import pss_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int RUN_BITS    = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   level,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  pss_cfg_t               cfg,
    output pss_result_t            result
);

    localparam int CMP_W = (RUN_BITS > THRESH_W) ? RUN_BITS : THRESH_W;
    localparam int SMP_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;
    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    logic [RUN_BITS-1:0] high_run_reg, high_run_next;
    logic [RUN_BITS-1:0] low_run_reg, low_run_next;
    logic [PERIOD_W-1:0] phase_reg, phase_next;
    logic                power_reg, power_next;
    pss_pins_t           pins_reg, pins_next;

    logic [RUN_BITS-1:0] high_inc;
    logic [RUN_BITS-1:0] low_inc;
    logic [CMP_W-1:0]    on_thr_cmp;
    logic [CMP_W-1:0]    off_thr_cmp;
    logic [PERIOD_W:0]   phase_inc;
    logic                check;
    logic                undervolt;

    // saturating run increments and widened thresholds
    assign high_inc    = (high_run_reg < RUN_MAX) ? high_run_reg + 1'b1 : high_run_reg;
    assign low_inc     = (low_run_reg < RUN_MAX) ? low_run_reg + 1'b1 : low_run_reg;
    assign on_thr_cmp  = CMP_W'(cfg.on_threshold);
    assign off_thr_cmp = CMP_W'(cfg.off_threshold);

    // check phase
    assign phase_inc = {1'b0, phase_reg} + 1'b1;
    assign check     = phase_inc >= {1'b0, cfg.sample_period};
    assign undervolt = SMP_W'(sample) < SMP_W'(cfg.undervolt_limit);

    // tick update
    always_comb
    begin
        high_run_next = high_run_reg;
        low_run_next  = low_run_reg;
        power_next    = power_reg;
        pins_next     = pins_reg;

        if (level)
        begin
            high_run_next = high_inc;
            low_run_next  = '0;
            if (CMP_W'(high_inc) >= on_thr_cmp)
            begin
                high_run_next = RUN_BITS'(on_thr_cmp);
                // switch off
                if (power_reg)
                begin
                    pins_next.boost  = 1'b1;
                    pins_next.sw     = 1'b1;
                    pins_next.status = 1'b0;
                    power_next       = 1'b0;
                end
            end
        end
        else
        begin
            high_run_next = '0;
            low_run_next  = low_inc;
            if (CMP_W'(low_inc) > off_thr_cmp)
            begin
                low_run_next = RUN_BITS'(off_thr_cmp);
                // switch on
                if (!power_reg)
                begin
                    pins_next.boost     = 1'b0;
                    pins_next.sw        = 1'b0;
                    pins_next.status    = 1'b1;
                    pins_next.discharge = 1'b1;
                    power_next          = 1'b1;
                end
            end
        end

        phase_next = check ? '0 : phase_inc[PERIOD_W-1:0];

        // full shutdown on undervoltage while off
        if (check && !power_next && undervolt)
        begin
            pins_next.discharge = 1'b0;
            pins_next.boost     = 1'b0;
            pins_next.sw        = 1'b0;
        end
    end

    // result record
    always_comb
    begin
        result.powered         = power_next;
        result.boost_drive     = pins_next.boost;
        result.switch_drive    = pins_next.sw;
        result.status_drive    = pins_next.status;
        result.discharge_drive = pins_next.discharge;
        result.checked         = check;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_run_reg <= '0;
            low_run_reg  <= '0;
            phase_reg    <= '0;
            power_reg    <= 1'b1;
            pins_reg     <= PINS_RST;
        end
        else if (advance)
        begin
            high_run_reg <= high_run_next;
            low_run_reg  <= low_run_next;
            phase_reg    <= phase_next;
            power_reg    <= power_next;
            pins_reg     <= pins_next;
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the power switch sequencer. A bit-accurate pin model
// runs beside the block and predicts the pin levels of every tick request;
// each result is checked field by field against the oldest prediction.
// Directed checks of switching, shutdown, check timing and register masking
// come first, then phases of random sense runs sized around the thresholds
// under random register settings, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb;
    import pss_pkg::*;

    localparam int SAMPLE_BITS    = 10;
    localparam int RUN_BITS       = 8;
    localparam int RESULT_LATENCY = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 240;

    // index range with no register behind it
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    localparam logic [RUN_BITS-1:0] RUN_ALL_ONES = '1;

    logic clk;
    logic rst_n;

    pss_tick_if #(.SAMPLE_BITS(SAMPLE_BITS)) tick_ch ();
    pss_result_if                            res_ch ();
    pss_cfg_if                               cfg_ch ();

    power_switch_sequencer #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RUN_BITS    (RUN_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (tick_ch),
        .result_out (res_ch),
        .cfg        (cfg_ch)
    );

    // pin model state and register copy
    pss_cfg_t            model_cfg;
    pss_pins_t           model_pins;
    logic                model_on;
    logic [RUN_BITS-1:0] high_count;
    logic [RUN_BITS-1:0] low_count;
    logic [PERIOD_W-1:0] phase_count;

    pss_result_t expected_pins[$];
    int          err_count;
    bit          bursts_on;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // advance the pin model by one tick and return the pin levels it gives
    function automatic pss_result_t advance_pins(input logic level,
                                                 input logic [SAMPLE_BITS-1:0] sample);
        logic        check_now;
        pss_result_t r;
        if (level)
        begin
            if (high_count != RUN_ALL_ONES)
                high_count = high_count + 1'b1;
            low_count = '0;
            if (high_count >= model_cfg.on_threshold)
            begin
                high_count = model_cfg.on_threshold;
                if (model_on)
                begin
                    model_pins.boost  = 1'b1;
                    model_pins.sw     = 1'b1;
                    model_pins.status = 1'b0;
                    model_on          = 1'b0;
                end
            end
        end
        else
        begin
            high_count = '0;
            if (low_count != RUN_ALL_ONES)
                low_count = low_count + 1'b1;
            if (low_count > model_cfg.off_threshold)
            begin
                low_count = model_cfg.off_threshold;
                if (!model_on)
                begin
                    model_pins.boost     = 1'b0;
                    model_pins.sw        = 1'b0;
                    model_pins.status    = 1'b1;
                    model_pins.discharge = 1'b1;
                    model_on             = 1'b1;
                end
            end
        end

        // phase counter and undervoltage check on the post-update state
        check_now = (int'(phase_count) + 1) >= int'(model_cfg.sample_period);
        if (check_now)
            phase_count = '0;
        else
            phase_count = phase_count + 1'b1;
        if (check_now && !model_on && (sample < model_cfg.undervolt_limit))
        begin
            model_pins.discharge = 1'b0;
            model_pins.boost     = 1'b0;
            model_pins.sw        = 1'b0;
        end

        r.powered         = model_on;
        r.boost_drive     = model_pins.boost;
        r.switch_drive    = model_pins.sw;
        r.status_drive    = model_pins.status;
        r.discharge_drive = model_pins.discharge;
        r.checked         = check_now;
        return r;
    endfunction

    // send one tick request, with an optional idle burst in front
    task automatic send_tick(input logic level, input logic [SAMPLE_BITS-1:0] sample);
        int gap;
        @(negedge clk);
        if (bursts_on && ($urandom_range(0, 7) == 0))
        begin
            gap           = $urandom_range(1, 18);
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid         = 1'b1;
        tick_ch.sense_level   = level;
        tick_ch.supply_sample = sample;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        expected_pins.push_back(advance_pins(level, sample));
    endtask

    // drop the tick request and wait until every result is in
    task automatic settle();
        @(negedge clk);
        tick_ch.valid = 1'b0;
        wait (expected_pins.size() == 0);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_ON_THRESHOLD:    model_cfg.on_threshold    = data[THRESH_W-1:0];
            CFG_OFF_THRESHOLD:   model_cfg.off_threshold   = data[THRESH_W-1:0];
            CFG_SAMPLE_PERIOD:   model_cfg.sample_period   = data[PERIOD_W-1:0];
            CFG_UNDERVOLT_LIMIT: model_cfg.undervolt_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // supply sample, often just around the limit
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] s;
        if ($urandom_range(0, 3) == 0)
        begin
            s = model_cfg.undervolt_limit;
            s = s + SAMPLE_BITS'($urandom_range(0, 2));
            s = s - 1'b1;
        end
        else
            s = SAMPLE_BITS'($urandom_range(0, 1023));
        return s;
    endfunction

    // random settings, extremes among them, upper data bits as noise
    task automatic pick_settings();
        logic [CFG_DATA_W-1:0] raw;
        raw = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 6))
            0: raw[THRESH_W-1:0] = '0;
            1: raw[THRESH_W-1:0] = '1;
            2: raw[THRESH_W-1:0] = 8'd254;
            default: raw[THRESH_W-1:0] = THRESH_W'($urandom_range(1, 12));
        endcase
        write_reg(CFG_ON_THRESHOLD, raw);
        raw = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 6))
            0: raw[THRESH_W-1:0] = '0;
            1: raw[THRESH_W-1:0] = '1;
            2: raw[THRESH_W-1:0] = 8'd254;
            default: raw[THRESH_W-1:0] = THRESH_W'($urandom_range(1, 12));
        endcase
        write_reg(CFG_OFF_THRESHOLD, raw);
        case ($urandom_range(0, 6))
            0: raw = '0;
            1: raw = 16'd1;
            2: raw = '1;
            3: raw = CFG_DATA_W'($urandom_range(16, 200));
            default: raw = CFG_DATA_W'($urandom_range(2, 15));
        endcase
        write_reg(CFG_SAMPLE_PERIOD, raw);
        raw = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 4))
            0: raw[LIMIT_W-1:0] = '0;
            1: raw[LIMIT_W-1:0] = '1;
            default: raw[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 1023));
        endcase
        write_reg(CFG_UNDERVOLT_LIMIT, raw);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)),
                      CFG_DATA_W'($urandom));
    endtask

    // defaults straight out of reset
    task automatic test_reset_state();
        send_tick(1'b0, '0);
        send_tick(1'b1, '1);
        settle();
    endtask

    // switching both ways, repeated commands and undervoltage shutdown
    task automatic test_switching();
        write_reg(CFG_ON_THRESHOLD, 16'hFF01);
        write_reg(CFG_OFF_THRESHOLD, 16'h5A00);
        write_reg(CFG_SAMPLE_PERIOD, 16'd1);
        write_reg(CFG_UNDERVOLT_LIMIT, 16'hFFFF);
        send_tick(1'b1, '0);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b0, 10'd1023);
        send_tick(1'b0, '0);
        send_tick(1'b1, 10'd1022);
        settle();
        // zero on threshold, then a limit that no sample is below
        write_reg(CFG_ON_THRESHOLD, 16'hAB00);
        send_tick(1'b0, '0);
        send_tick(1'b1, '0);
        settle();
        write_reg(CFG_UNDERVOLT_LIMIT, 16'hFC00);
        send_tick(1'b1, '0);
        send_tick(1'b0, '0);
        settle();
    endtask

    // check spacing, period change below the phase, unmapped index
    task automatic test_check_timing();
        write_reg(CFG_UNDERVOLT_LIMIT, 16'd512);
        write_reg(CFG_SAMPLE_PERIOD, 16'd0);
        send_tick(1'b1, 10'd3);
        send_tick(1'b1, 10'd600);
        settle();
        write_reg(CFG_SAMPLE_PERIOD, 16'hFFFF);
        repeat (4) send_tick(1'b0, 10'd100);
        settle();
        write_reg(CFG_SAMPLE_PERIOD, 16'd2);
        send_tick(1'b1, 10'd100);
        settle();
        write_reg(CFG_INDEX_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)),
                  CFG_DATA_W'($urandom));
        send_tick(1'b1, 10'd0);
        send_tick(1'b0, 10'd0);
        settle();
    endtask

    // sense runs sized around the thresholds, with noise bursts between
    task automatic test_random_runs(input int n_items);
        int   sent;
        int   run_len;
        logic level;
        sent  = 0;
        level = 1'($urandom_range(0, 1));
        while (sent < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                run_len = int'($urandom_range(1, 4));
                repeat (run_len) send_tick(1'($urandom_range(0, 1)), pick_sample());
            end
            else
            begin
                if (level)
                    run_len = int'(model_cfg.on_threshold) + int'($urandom_range(0, 2)) - 1;
                else
                    run_len = int'(model_cfg.off_threshold) + int'($urandom_range(0, 2));
                if (run_len < 1)
                    run_len = 1;
                repeat (run_len) send_tick(level, pick_sample());
                level = !level;
            end
            sent += run_len;
        end
        settle();
    endtask

    // result side: random stall bursts, ready high at least once between
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        stall        = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall        = stall - 1;
                res_ch.ready = 1'b0;
            end
            else if (bursts_on && res_ch.ready && ($urandom_range(0, 7) == 0))
            begin
                stall        = $urandom_range(1, 18) - 1;
                res_ch.ready = 1'b0;
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        pss_result_t act;
        pss_result_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            act.powered         = res_ch.powered;
            act.boost_drive     = res_ch.boost_drive;
            act.switch_drive    = res_ch.switch_drive;
            act.status_drive    = res_ch.status_drive;
            act.discharge_drive = res_ch.discharge_drive;
            act.checked         = res_ch.checked;
            if (expected_pins.size() == 0)
            begin
                err_count = err_count + 1;
                if (err_count <= MAX_REPORTS)
                    $display("[%0t] result with no prediction: %b", $realtime, act);
            end
            else
            begin
                exp_r = expected_pins.pop_front();
                if ((act.powered !== exp_r.powered) ||
                    (act.boost_drive !== exp_r.boost_drive) ||
                    (act.switch_drive !== exp_r.switch_drive) ||
                    (act.status_drive !== exp_r.status_drive) ||
                    (act.discharge_drive !== exp_r.discharge_drive) ||
                    (act.checked !== exp_r.checked))
                begin
                    err_count = err_count + 1;
                    // field order: powered, boost, switch, status, discharge, checked
                    if (err_count <= MAX_REPORTS)
                        $display("[%0t] mismatch exp %b%b%b%b%b%b act %b%b%b%b%b%b",
                                 $realtime,
                                 exp_r.powered, exp_r.boost_drive, exp_r.switch_drive,
                                 exp_r.status_drive, exp_r.discharge_drive, exp_r.checked,
                                 act.powered, act.boost_drive, act.switch_drive,
                                 act.status_drive, act.discharge_drive, act.checked);
                end
            end
        end
    end

    // watchdog on cycles with no request accepted anywhere
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("power_switch_sequencer regression: fail");
        $finish;
    end

    // main sequence
    initial
    begin
        int ph;
        rst_n                 = 1'b0;
        tick_ch.valid         = 1'b0;
        tick_ch.sense_level   = 1'b0;
        tick_ch.supply_sample = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        err_count             = 0;
        bursts_on             = 1'b1;
        model_cfg             = '{on_threshold:    ON_THRESHOLD_RST,
                                  off_threshold:   OFF_THRESHOLD_RST,
                                  sample_period:   SAMPLE_PERIOD_RST,
                                  undervolt_limit: UNDERVOLT_LIMIT_RST};
        model_pins            = PINS_RST;
        model_on              = 1'b1;
        high_count            = '0;
        low_count             = '0;
        phase_count           = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_switching();
        test_check_timing();
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // last phase runs with no idling on either side
            if (ph == RANDOM_PHASES - 1)
                bursts_on = 1'b0;
            pick_settings();
            test_random_runs(PHASE_ITEMS);
        end

        settle();
        repeat (4 * RESULT_LATENCY) @(posedge clk);
        if ((err_count == 0) && (expected_pins.size() == 0))
            $display("power_switch_sequencer regression: pass");
        else
            $display("power_switch_sequencer regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/pss_pkg.sv
src/pss_if.sv
src/pss_core.sv
src/power_switch_sequencer.sv
tb/tb.sv
